// File: hw/rtl/khid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khid_pkg
// Shared types, codes and lookup functions of the HID keyboard report block.
// ----------------------------------------------------------------------------
package khid_pkg;

    localparam int VK_W     = 8;
    localparam int USAGE_W  = 8;
    localparam int REPORT_SLOTS = 6;

    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_RESET   = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_HELD = 2'd3
    } t_status;

    // Generic modifier keys map to one bit of the modifier byte, others to zero.
    function automatic logic [USAGE_W-1:0] modifier_bit(input logic [VK_W-1:0] vk);
        logic [USAGE_W-1:0] m;
        m = '0;
        case (vk)
            8'h10:   m = 8'h02;
            8'h11:   m = 8'h01;
            8'h12:   m = 8'h04;
            8'h5B:   m = 8'h08;
            8'h5C:   m = 8'h80;
            default: m = '0;
        endcase
        return m;
    endfunction

    // Virtual-key to HID usage; zero means unmapped.
    function automatic logic [USAGE_W-1:0] vk_to_usage(input logic [VK_W-1:0] vk);
        logic [USAGE_W-1:0] u;
        u = '0;
        case (vk)
            8'h08: u = 8'h2A; 8'h09: u = 8'h2B; 8'h0D: u = 8'h28; 8'h13: u = 8'h48;
            8'h14: u = 8'h39; 8'h15: u = 8'h90; 8'h1B: u = 8'h29; 8'h20: u = 8'h2C;
            8'h21: u = 8'h4B; 8'h22: u = 8'h4E; 8'h23: u = 8'h4D; 8'h24: u = 8'h4A;
            8'h25: u = 8'h50; 8'h26: u = 8'h52; 8'h27: u = 8'h4F; 8'h28: u = 8'h51;
            8'h2B: u = 8'h74; 8'h2C: u = 8'h46; 8'h2D: u = 8'h49; 8'h2E: u = 8'h4C;
            8'h2F: u = 8'h75;
            8'h30: u = 8'h27; 8'h31: u = 8'h1E; 8'h32: u = 8'h1F; 8'h33: u = 8'h20;
            8'h34: u = 8'h21; 8'h35: u = 8'h22; 8'h36: u = 8'h23; 8'h37: u = 8'h24;
            8'h38: u = 8'h25; 8'h39: u = 8'h26;
            8'h41: u = 8'h04; 8'h42: u = 8'h05; 8'h43: u = 8'h06; 8'h44: u = 8'h07;
            8'h45: u = 8'h08; 8'h46: u = 8'h09; 8'h47: u = 8'h0A; 8'h48: u = 8'h0B;
            8'h49: u = 8'h0C; 8'h4A: u = 8'h0D; 8'h4B: u = 8'h0E; 8'h4C: u = 8'h0F;
            8'h4D: u = 8'h10; 8'h4E: u = 8'h11; 8'h4F: u = 8'h12; 8'h50: u = 8'h13;
            8'h51: u = 8'h14; 8'h52: u = 8'h15; 8'h53: u = 8'h16; 8'h54: u = 8'h17;
            8'h55: u = 8'h18; 8'h56: u = 8'h19; 8'h57: u = 8'h1A; 8'h58: u = 8'h1B;
            8'h59: u = 8'h1C; 8'h5A: u = 8'h1D;
            8'h5B: u = 8'hE3; 8'h5C: u = 8'hE7; 8'h5D: u = 8'h65; 8'h5F: u = 8'hF8;
            8'h60: u = 8'h62; 8'h61: u = 8'h59; 8'h62: u = 8'h5A; 8'h63: u = 8'h5B;
            8'h64: u = 8'h5C; 8'h65: u = 8'h5D; 8'h66: u = 8'h5E; 8'h67: u = 8'h5F;
            8'h68: u = 8'h60; 8'h69: u = 8'h61;
            8'h6A: u = 8'h55; 8'h6B: u = 8'h57; 8'h6C: u = 8'h58; 8'h6D: u = 8'h56;
            8'h6E: u = 8'h63; 8'h6F: u = 8'h54;
            8'h70: u = 8'h3A; 8'h71: u = 8'h3B; 8'h72: u = 8'h3C; 8'h73: u = 8'h3D;
            8'h74: u = 8'h3E; 8'h75: u = 8'h3F; 8'h76: u = 8'h40; 8'h77: u = 8'h41;
            8'h78: u = 8'h42; 8'h79: u = 8'h43; 8'h7A: u = 8'h44; 8'h7B: u = 8'h45;
            8'h7C: u = 8'h68; 8'h7D: u = 8'h69; 8'h7E: u = 8'h6A; 8'h7F: u = 8'h6B;
            8'h80: u = 8'h6C; 8'h81: u = 8'h6D; 8'h82: u = 8'h6E; 8'h83: u = 8'h6F;
            8'h84: u = 8'h70; 8'h85: u = 8'h71; 8'h86: u = 8'h72; 8'h87: u = 8'h73;
            8'h90: u = 8'h53; 8'h91: u = 8'h47;
            8'hA0: u = 8'hE1; 8'hA1: u = 8'hE5; 8'hA2: u = 8'hE0; 8'hA3: u = 8'hE4;
            8'hA4: u = 8'hE2; 8'hA5: u = 8'hE6;
            8'hA6: u = 8'hF1; 8'hA7: u = 8'hF2; 8'hA8: u = 8'hFA; 8'hA9: u = 8'hF3;
            8'hAA: u = 8'hF4; 8'hAB: u = 8'hF9; 8'hAC: u = 8'hF0; 8'hAD: u = 8'hEF;
            8'hAE: u = 8'hEE; 8'hAF: u = 8'hED; 8'hB0: u = 8'hEB; 8'hB1: u = 8'hEA;
            8'hB2: u = 8'hE9; 8'hB3: u = 8'hE8;
            8'hBA: u = 8'h33; 8'hBB: u = 8'h2E; 8'hBC: u = 8'h36; 8'hBD: u = 8'h2D;
            8'hBE: u = 8'h37; 8'hBF: u = 8'h38; 8'hC0: u = 8'h35;
            8'hDB: u = 8'h2F; 8'hDC: u = 8'h31; 8'hDD: u = 8'h30; 8'hDE: u = 8'h34;
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/khid_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khid_slot_mem
// Key slot store: one write port, one registered read port. Per-entry valid
// bits make a never-written or cleared entry read as empty.
// ----------------------------------------------------------------------------
module khid_slot_mem #(
    parameter int DEPTH = 6,
    parameter int AW    = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_rd_en,
    input  wire logic [AW-1:0]                 i_rd_addr,
    input  wire logic                          i_wr_en,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [khid_pkg::USAGE_W-1:0]  i_wr_data,
    output logic      [khid_pkg::USAGE_W-1:0]  o_rd_data
);
    import khid_pkg::*;

    logic [USAGE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic [USAGE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: hw/rtl/key_event_to_hid_keyboard_report_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_to_hid_keyboard_report_top
// Turns key press, release and reset events into a boot keyboard report.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. Any other event than
// a reset walks the slot memory one entry per cycle (one registered read
// port), then updates one slot; the result strobe o_result_valid is
// registered in the update state, and a new event can be given in that
// strobe cycle. A reset event needs no walk and answers in the cycle after
// it is taken, with busy staying low.
// The report is shown for exactly one cycle and cannot be held off, so the
// receiver must capture it on the strobe.
module key_event_to_hid_keyboard_report_top #(
    parameter int SLOT_COUNT = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_vk_code,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [7:0]       o_modifier_bits,
    output logic [7:0]       o_slot_key0,
    output logic [7:0]       o_slot_key1,
    output logic [7:0]       o_slot_key2,
    output logic [7:0]       o_slot_key3,
    output logic [7:0]       o_slot_key4,
    output logic [7:0]       o_slot_key5
);
    import khid_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state             r_state;
    t_func              r_func;
    logic [USAGE_W-1:0] r_usage;
    logic [USAGE_W-1:0] r_mod;
    logic [CW-1:0]      r_idx;
    logic [USAGE_W-1:0] r_slot [SLOT_COUNT];
    logic [USAGE_W-1:0] r_mods;
    t_status            r_status;
    logic               r_out_valid;

    logic [USAGE_W-1:0] n_mods;
    t_status            n_status;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [USAGE_W-1:0] w_wr_data;
    logic               w_hit;
    logic [AW-1:0]      w_hit_idx;
    logic               w_free;
    logic [AW-1:0]      w_free_idx;
    logic               w_clear;
    logic               w_rd_en;
    logic [USAGE_W-1:0] w_rd_data;
    logic [CW-1:0]      w_cap_idx;
    logic [USAGE_W-1:0] w_view [REPORT_SLOTS];

    assign busy      = (r_state != S_IDLE);
    assign w_clear   = (r_state == S_IDLE) && start && (t_func'(i_func) == FUNC_RESET);
    assign w_rd_en   = (r_state == S_SCAN) && (r_idx != LAST_IDX);
    assign w_cap_idx = r_idx - CW'(1);

    khid_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // Lowest slot that holds the usage, and lowest empty slot.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_slot[i] == r_usage) begin
                w_hit     = 1'b1;
                w_hit_idx = AW'(i);
            end
            if (r_slot[i] == '0) begin
                w_free     = 1'b1;
                w_free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        n_mods    = r_mods;
        n_status  = ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = w_hit_idx;
        w_wr_data = '0;
        if (r_state == S_UPDATE) begin
            unique case (r_func)
                FUNC_PRESS: begin
                    priority if (r_mod != '0) begin
                        n_mods = r_mods | r_mod;
                    end else if (r_usage == '0) begin
                        n_status = ST_UNMAPPED;
                    end else if (w_hit) begin
                        n_status = ST_OK;
                    end else if (w_free) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_free_idx;
                        w_wr_data = r_usage;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                FUNC_RELEASE: begin
                    priority if (r_mod != '0) begin
                        n_mods = r_mods & ~r_mod;
                    end else if (r_usage == '0) begin
                        n_status = ST_UNMAPPED;
                    end else if (w_hit) begin
                        w_wr_en = 1'b1;
                    end else begin
                        n_status = ST_NOT_HELD;
                    end
                end
                FUNC_RESET, FUNC_NONE: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mods      <= '0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= t_func'(i_func);
                        r_usage <= vk_to_usage(i_vk_code);
                        r_mod   <= modifier_bit(i_vk_code);
                        if (t_func'(i_func) == FUNC_RESET) begin
                            r_mods      <= '0;
                            r_status    <= ST_OK;
                            r_out_valid <= 1'b1;
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                r_slot[i] <= '0;
                            end
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Read data is registered and belongs to the previous address.
                    if (r_idx != '0) begin
                        r_slot[w_cap_idx[AW-1:0]] <= w_rd_data;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_UPDATE: begin
                    r_mods      <= n_mods;
                    r_status    <= n_status;
                    r_out_valid <= 1'b1;
                    if (w_wr_en) begin
                        r_slot[w_wr_addr] <= w_wr_data;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Slots past SLOT_COUNT show as empty in the report.
    for (genvar j = 0; j < REPORT_SLOTS; j++) begin : g_view
        if (j < SLOT_COUNT) begin : g_used
            assign w_view[j] = r_slot[j];
        end else begin : g_empty
            assign w_view[j] = '0;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_status        = r_status;
    assign o_modifier_bits = r_mods;
    assign o_slot_key0     = w_view[0];
    assign o_slot_key1     = w_view[1];
    assign o_slot_key2     = w_view[2];
    assign o_slot_key3     = w_view[3];
    assign o_slot_key4     = w_view[4];
    assign o_slot_key5     = w_view[5];

endmodule
`default_nettype wire

// File: hw/rtl/khid_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khid_checker
// Port-level timing checks of the HID keyboard report block.
// ----------------------------------------------------------------------------
module khid_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_func,
    input wire logic       o_result_valid,
    input wire logic [1:0] o_status,
    input wire logic [7:0] o_modifier_bits
);
    import khid_pkg::*;

    logic w_accept;
    assign w_accept = start && !busy;

    // The report beat only appears once the block has gone idle.
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result beat while busy");

    // A reset event answers next cycle with an empty modifier byte.
    a_reset_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_func == FUNC_RESET)) |=>
            (o_result_valid && (o_status == ST_OK) && (o_modifier_bits == '0)))
        else $error("reset event not answered");

    // Any other event holds the block busy.
    a_event_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_func != FUNC_RESET)) |=> busy)
        else $error("event taken without going busy");

    // Busy drops only together with a result beat.
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_result_valid)
        else $error("busy dropped without a result beat");

endmodule

bind key_event_to_hid_keyboard_report_top khid_checker u_khid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_func          (i_func),
    .o_result_valid  (o_result_valid),
    .o_status        (o_status),
    .o_modifier_bits (o_modifier_bits)
);
`default_nettype wire

// File: bench/hid_report_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hid_report_checker
// Watches the event and report channels of the keyboard report block, keeps
// its own copy of the held keys and modifier byte, and compares every report
// strobe with the report predicted for the oldest outstanding event.
// ----------------------------------------------------------------------------
module hid_report_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_vk_code,
    input  wire logic       o_result_valid,
    input  wire logic [1:0] o_status,
    input  wire logic [7:0] o_modifier_bits,
    input  wire logic [7:0] o_slot_key0,
    input  wire logic [7:0] o_slot_key1,
    input  wire logic [7:0] o_slot_key2,
    input  wire logic [7:0] o_slot_key3,
    input  wire logic [7:0] o_slot_key4,
    input  wire logic [7:0] o_slot_key5,
    output int              o_fail_count,
    output int              o_pending
);
    import khid_pkg::*;

    localparam int KEY_SLOTS    = 6;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        t_status                      status;
        logic [7:0]                   modifiers;
        logic [KEY_SLOTS-1:0][7:0]    keys;
    } t_hid_report;

    logic [7:0]  vk_usage [256];
    logic [7:0]  held_keys [KEY_SLOTS];
    logic [7:0]  held_mods;
    t_hid_report expected_reports [$];
    t_hid_report seen_report;
    t_hid_report want_report;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held_mods    = '0;
        foreach (held_keys[i]) held_keys[i] = '0;
        foreach (vk_usage[i]) vk_usage[i] = '0;
        vk_usage['h08] = 'h2A; vk_usage['h09] = 'h2B; vk_usage['h0D] = 'h28;
        vk_usage['h13] = 'h48; vk_usage['h14] = 'h39; vk_usage['h15] = 'h90;
        vk_usage['h1B] = 'h29; vk_usage['h20] = 'h2C; vk_usage['h21] = 'h4B;
        vk_usage['h22] = 'h4E; vk_usage['h23] = 'h4D; vk_usage['h24] = 'h4A;
        vk_usage['h25] = 'h50; vk_usage['h26] = 'h52; vk_usage['h27] = 'h4F;
        vk_usage['h28] = 'h51; vk_usage['h2B] = 'h74; vk_usage['h2C] = 'h46;
        vk_usage['h2D] = 'h49; vk_usage['h2E] = 'h4C; vk_usage['h2F] = 'h75;
        // digits 0..9
        for (int d = 0; d < 10; d++) vk_usage[8'h30 + d] = (d == 0) ? 8'h27 : 8'(8'h1D + d);
        // letters A..Z
        for (int a = 0; a < 26; a++) vk_usage[8'h41 + a] = 8'(8'h04 + a);
        vk_usage['h5B] = 'hE3; vk_usage['h5C] = 'hE7; vk_usage['h5D] = 'h65;
        vk_usage['h5F] = 'hF8; vk_usage['h60] = 'h62;
        // keypad 1..9
        for (int k = 1; k < 10; k++) vk_usage[8'h60 + k] = 8'(8'h58 + k);
        vk_usage['h6A] = 'h55; vk_usage['h6B] = 'h57; vk_usage['h6C] = 'h58;
        vk_usage['h6D] = 'h56; vk_usage['h6E] = 'h63; vk_usage['h6F] = 'h54;
        // F1..F12, then F13..F24
        for (int f = 0; f < 12; f++) vk_usage[8'h70 + f] = 8'(8'h3A + f);
        for (int f = 0; f < 12; f++) vk_usage[8'h7C + f] = 8'(8'h68 + f);
        vk_usage['h90] = 'h53; vk_usage['h91] = 'h47;
        vk_usage['hA0] = 'hE1; vk_usage['hA1] = 'hE5; vk_usage['hA2] = 'hE0;
        vk_usage['hA3] = 'hE4; vk_usage['hA4] = 'hE2; vk_usage['hA5] = 'hE6;
        vk_usage['hA6] = 'hF1; vk_usage['hA7] = 'hF2; vk_usage['hA8] = 'hFA;
        vk_usage['hA9] = 'hF3; vk_usage['hAA] = 'hF4; vk_usage['hAB] = 'hF9;
        vk_usage['hAC] = 'hF0; vk_usage['hAD] = 'hEF; vk_usage['hAE] = 'hEE;
        vk_usage['hAF] = 'hED; vk_usage['hB0] = 'hEB; vk_usage['hB1] = 'hEA;
        vk_usage['hB2] = 'hE9; vk_usage['hB3] = 'hE8;
        vk_usage['hBA] = 'h33; vk_usage['hBB] = 'h2E; vk_usage['hBC] = 'h36;
        vk_usage['hBD] = 'h2D; vk_usage['hBE] = 'h37; vk_usage['hBF] = 'h38;
        vk_usage['hC0] = 'h35; vk_usage['hDB] = 'h2F; vk_usage['hDC] = 'h31;
        vk_usage['hDD] = 'h30; vk_usage['hDE] = 'h34;
    end

    // Apply one event to the held state and return the report it produces.
    function automatic t_hid_report predict_report(t_func func, logic [7:0] vk);
        t_hid_report rep;
        logic [7:0]  mod_bit;
        logic [7:0]  usage;
        int          hit;
        int          free;
        int          i;
        rep.status = ST_OK;
        case (vk)
            8'h10:   mod_bit = 8'h02;
            8'h11:   mod_bit = 8'h01;
            8'h12:   mod_bit = 8'h04;
            8'h5B:   mod_bit = 8'h08;
            8'h5C:   mod_bit = 8'h80;
            default: mod_bit = 8'h00;
        endcase
        usage = vk_usage[vk];
        hit   = -1;
        free  = -1;
        for (i = 0; i < KEY_SLOTS; i++) begin
            if (hit < 0 && held_keys[i] == usage) hit = i;
            if (free < 0 && held_keys[i] == 8'h00) free = i;
        end
        case (func)
            FUNC_PRESS: begin
                if (mod_bit != 8'h00) begin
                    held_mods = held_mods | mod_bit;
                end else if (usage == 8'h00) begin
                    rep.status = ST_UNMAPPED;
                end else if (hit < 0) begin
                    // repeated press of a held usage leaves the table alone
                    if (free >= 0) held_keys[free] = usage;
                    else rep.status = ST_FULL;
                end
            end
            FUNC_RELEASE: begin
                if (mod_bit != 8'h00) begin
                    held_mods = held_mods & ~mod_bit;
                end else if (usage == 8'h00) begin
                    rep.status = ST_UNMAPPED;
                end else if (hit < 0) begin
                    rep.status = ST_NOT_HELD;
                end else begin
                    held_keys[hit] = 8'h00;
                end
            end
            FUNC_RESET: begin
                held_mods = 8'h00;
                for (i = 0; i < KEY_SLOTS; i++) held_keys[i] = 8'h00;
            end
            default: ;
        endcase
        rep.modifiers = held_mods;
        for (i = 0; i < KEY_SLOTS; i++) rep.keys[i] = held_keys[i];
        return rep;
    endfunction

    function automatic void note_error(string what, int want, int got);
        if (o_fail_count < SHOWN_ERRORS)
            $display("%0t report mismatch on %s: expected %02h, got %02h",
                     $realtime, what, want, got);
        o_fail_count++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_mods = 8'h00;
            foreach (held_keys[i]) held_keys[i] = 8'h00;
            expected_reports.delete();
        end else begin
            // compare before pushing: a new beat may land in the strobe cycle
            if (o_result_valid) begin
                seen_report = {t_status'(o_status), o_modifier_bits, o_slot_key5,
                               o_slot_key4, o_slot_key3, o_slot_key2, o_slot_key1,
                               o_slot_key0};
                if (expected_reports.size() == 0) begin
                    note_error("unexpected report status", 0, seen_report.status);
                end else begin
                    want_report = expected_reports.pop_front();
                    if (seen_report.status != want_report.status)
                        note_error("status", want_report.status, seen_report.status);
                    if (seen_report.modifiers != want_report.modifiers)
                        note_error("modifier byte", want_report.modifiers,
                                   seen_report.modifiers);
                    for (int s = 0; s < KEY_SLOTS; s++)
                        if (seen_report.keys[s] != want_report.keys[s])
                            note_error($sformatf("key slot %0d", s), want_report.keys[s],
                                       seen_report.keys[s]);
                end
            end
            if (start && !busy)
                expected_reports.push_back(predict_report(t_func'(i_func), i_vk_code));
        end
        o_pending = expected_reports.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives key events into the HID keyboard report block: a directed pass over
// modifiers, unmapped codes, repeated presses, a full table and releases of
// keys not held, then random event streams sent in bursts with gaps.
// ----------------------------------------------------------------------------
module tb;
    import khid_pkg::*;

    localparam int SLOT_COUNT    = 6;
    localparam int RANDOM_EVENTS = 1000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_EVERY   = 250;

    localparam logic [7:0] VK_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_SHIFT    = 8'h10;
    localparam logic [7:0] KEY_CTRL     = 8'h11;
    localparam logic [7:0] VK_ALT       = 8'h12;
    localparam logic [7:0] VK_UNMAPPED  = 8'h19;
    localparam logic [7:0] VK_A         = 8'h41;
    localparam logic [7:0] VK_LMETA     = 8'h5B;
    localparam logic [7:0] VK_RMETA     = 8'h5C;

    localparam logic [7:0] MOD_KEYS [5] = '{KEY_SHIFT, KEY_CTRL, VK_ALT, VK_LMETA, VK_RMETA};

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_func;
    logic [7:0] i_vk_code;
    logic       o_result_valid;
    logic [1:0] o_status;
    logic [7:0] o_modifier_bits;
    logic [7:0] o_slot_key0;
    logic [7:0] o_slot_key1;
    logic [7:0] o_slot_key2;
    logic [7:0] o_slot_key3;
    logic [7:0] o_slot_key4;
    logic [7:0] o_slot_key5;
    int         fail_count;
    int         pending_reports;
    int         idle_cycles = 0;

    key_event_to_hid_keyboard_report_top #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_vk_code      (i_vk_code),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_modifier_bits(o_modifier_bits),
        .o_slot_key0    (o_slot_key0),
        .o_slot_key1    (o_slot_key1),
        .o_slot_key2    (o_slot_key2),
        .o_slot_key3    (o_slot_key3),
        .o_slot_key4    (o_slot_key4),
        .o_slot_key5    (o_slot_key5)
    );

    hid_report_checker u_report_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_vk_code      (i_vk_code),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_modifier_bits(o_modifier_bits),
        .o_slot_key0    (o_slot_key0),
        .o_slot_key1    (o_slot_key1),
        .o_slot_key2    (o_slot_key2),
        .o_slot_key3    (o_slot_key3),
        .o_slot_key4    (o_slot_key4),
        .o_slot_key5    (o_slot_key5),
        .o_fail_count   (fail_count),
        .o_pending      (pending_reports)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // count cycles without an accepted beat or a report strobe
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Present one event and hold it until the block takes it.
    task automatic send_event(t_func func, logic [7:0] vk);
        @(negedge i_clk);
        start     <= 1'b1;
        i_func    <= func;
        i_vk_code <= vk;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(int cycles);
        @(negedge i_clk);
        start     <= 1'b0;
        i_func    <= 2'($urandom);
        i_vk_code <= 8'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain_reports();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_reports != 0) @(negedge i_clk);
    endtask

    // Mostly presses and releases on a small key pool, so the table fills,
    // repeats and misses; the rest is modifiers, resets and raw noise.
    task automatic pick_event(output t_func func, output logic [7:0] vk);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            func = FUNC_PRESS;
            vk   = VK_A + 8'($urandom_range(0, 8));
        end else if (roll < 70) begin
            func = FUNC_RELEASE;
            vk   = VK_A + 8'($urandom_range(0, 8));
        end else if (roll < 80) begin
            func = $urandom_range(0, 1) ? FUNC_RELEASE : FUNC_PRESS;
            vk   = MOD_KEYS[$urandom_range(0, 4)];
        end else if (roll < 82) begin
            func = FUNC_RESET;
            vk   = 8'($urandom);
        end else begin
            func = t_func'($urandom_range(0, 3));
            vk   = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin
        t_func      func;
        logic [7:0] vk;
        int         burst_left;

        start     = 1'b0;
        i_func    = FUNC_PRESS;
        i_vk_code = 8'h00;
        i_rst_n   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_event(FUNC_RESET, 8'hFF);
        send_event(FUNC_PRESS, 8'h00);
        send_event(FUNC_RELEASE, VK_UNMAPPED);
        send_event(FUNC_PRESS, 8'hFF);
        foreach (MOD_KEYS[m]) send_event(FUNC_PRESS, MOD_KEYS[m]);
        send_event(FUNC_RELEASE, VK_ALT);
        for (int k = 0; k < SLOT_COUNT; k++) send_event(FUNC_PRESS, VK_A + 8'(k));
        send_event(FUNC_PRESS, VK_A);
        send_event(FUNC_PRESS, VK_A + 8'(SLOT_COUNT));
        send_event(FUNC_RELEASE, VK_A + 8'd2);
        send_event(FUNC_RELEASE, VK_A + 8'd2);
        send_event(FUNC_PRESS, VK_BACKSPACE);
        send_event(FUNC_NONE, 8'hFF);
        send_event(FUNC_RESET, 8'h00);
        drain_reports();

        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % DRAIN_EVERY == DRAIN_EVERY / 2) begin
                drain_reports();
            end else if (burst_left == 0) begin
                hold_off($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            end
            pick_event(func, vk);
            send_event(func, vk);
            if (burst_left > 0) burst_left--;
        end

        drain_reports();
        repeat (SLOT_COUNT + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/khid_pkg.sv
hw/rtl/khid_slot_mem.sv
hw/rtl/key_event_to_hid_keyboard_report_top.sv
hw/rtl/khid_checker.sv
bench/hid_report_checker.sv
bench/tb.sv
